// ===== rtl/pcm_downmix_to_u8_mono_core_assert.svh =====
// assertion macros for the down-mixer
`ifndef PCM_DOWNMIX_TO_U8_MONO_CORE_ASSERT_SVH
`define PCM_DOWNMIX_TO_U8_MONO_CORE_ASSERT_SVH

// implication checked at every edge outside reset
`define PDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the next cycle
`define PDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdm_pkg.sv =====
package pdm_pkg;

  localparam int MaxChannels = 8;
  localparam int FracBits    = 24;
  localparam int SumW        = 36;
  localparam int ChanW       = $clog2(MaxChannels + 1);
  localparam int IdxW        = $clog2(MaxChannels);
  localparam int QuotW       = SumW;

  localparam logic [2:0] FmtInt16 = 3'd0;
  localparam logic [2:0] FmtInt24 = 3'd1;
  localparam logic [2:0] FmtInt32 = 3'd2;
  localparam logic [2:0] FmtFlt32 = 3'd3;
  localparam logic [2:0] FmtFlt64 = 3'd4;

  localparam logic RegFormat   = 1'b0;
  localparam logic RegChannels = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear;       // start a new frame
    logic accumulate;  // add decoded sample
    logic div_start;   // load divider
    logic div_step;    // one quotient bit
    logic finish;      // form output level
  } pdm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } pdm_sts_t;

  // ieee pattern to signed q2.frac, saturated
  function automatic logic signed [FracBits+2:0] float_to_fixed(
      input logic [63:0] bits, input logic dbl);
    logic        neg;
    logic [10:0] ef;
    logic [52:0] mant;
    logic        emax;
    logic        fz;
    logic signed [12:0] e;
    logic signed [12:0] sh;
    logic [52:0] mag;
    logic signed [FracBits+2:0] r;
    begin
      if (dbl) begin
        neg  = bits[63];
        ef   = bits[62:52];
        emax = (ef == 11'h7ff);
        fz   = (bits[51:0] == '0);
        mant = {(ef != '0), bits[51:0]};
        e    = (ef == '0) ? -13'sd1022 : $signed({2'b0, ef}) - 13'sd1023;
        sh   = e - 13'sd52 + 13'(FracBits);
      end else begin
        neg  = bits[31];
        ef   = {3'b0, bits[30:23]};
        emax = (bits[30:23] == 8'hff);
        fz   = (bits[22:0] == '0);
        mant = {29'b0, (bits[30:23] != '0), bits[22:0]};
        e    = (ef == '0) ? -13'sd126 : $signed({2'b0, ef}) - 13'sd127;
        sh   = e - 13'sd23 + 13'(FracBits);
      end
      if (emax && !fz) r = '0;
      else if (emax || e >= 13'sd1)
        r = neg ? -(27'sd1 <<< (FracBits + 1)) : (27'sd1 <<< (FracBits + 1)) - 27'sd1;
      else begin
        if (sh >= 0) mag = mant << sh[5:0];
        else if (sh <= -13'sd64) mag = '0;
        else mag = mant >> 6'(-sh);
        r = neg ? -$signed({1'b0, mag[FracBits+1:0]}) : $signed({1'b0, mag[FracBits+1:0]});
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/pdm_ctrl.sv =====
module pdm_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      in_fire,
  input  logic                      frame_end,
  input  logic                      out_free,
  input  pdm_pkg::pdm_sts_t         sts,
  output pdm_pkg::pdm_cmd_t         cmd,
  output logic                      busy
);
  import pdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (cfg_write) cmd.clear = 1'b1;
        else if (in_fire) begin
          cmd.accumulate = 1'b1;
          if (frame_end) begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== rtl/pdm_dp.sv =====
module pdm_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  pdm_pkg::pdm_cmd_t      cmd,
  input  logic [2:0]             fmt,
  input  logic [pdm_pkg::ChanW-1:0] nch,
  input  logic [63:0]            sample_bits,
  output logic                   frame_end,
  output pdm_pkg::pdm_sts_t      sts,
  output logic [7:0]             level
);
  import pdm_pkg::*;

  logic signed [SumW-1:0] frame_sum;
  logic [IdxW:0]          channel_index;
  logic signed [SumW-1:0] samp;
  logic [SumW-1:0]        rem, quot;
  logic [SumW-1:0]        dividend;
  logic                   neg;
  logic [5:0]             cnt;
  logic [SumW:0]          trial;
  logic signed [SumW-1:0] avg;
  logic [2:0]             fmt_eff;
  logic signed [SumW+9:0] t;
  logic [SumW-1:0]        biased;

  assign fmt_eff = (fmt > FmtFlt64) ? FmtInt16 : fmt;

  always_comb begin
    unique case (fmt_eff)
      FmtInt24: samp = SumW'($signed(sample_bits[23:0]));
      FmtInt32: samp = SumW'($signed(sample_bits[31:0]));
      FmtFlt32: samp = SumW'(float_to_fixed(sample_bits, 1'b0));
      FmtFlt64: samp = SumW'(float_to_fixed(sample_bits, 1'b1));
      default:  samp = SumW'($signed(sample_bits[15:0]));
    endcase
  end

  assign frame_end = ({1'b0, channel_index} + 1'b1) >= (IdxW+2)'(nch);
  assign sts.div_done = (cnt == '0);
  assign trial = {rem, dividend[SumW-1]} - {{(SumW-ChanW+1){1'b0}}, nch};
  assign avg = neg ? -$signed(quot) : $signed(quot);
  assign t = ((SumW+10)'(avg) + (SumW+10)'(1 << FracBits)) * 255
             + (SumW+10)'(1 << FracBits);

  always_comb begin
    unique case (fmt_eff)
      FmtInt24: biased = avg + SumW'(1 << 23);
      FmtInt32: biased = avg + SumW'(64'd1 << 31);
      default:  biased = avg + SumW'(1 << 15);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      frame_sum <= '0;
      channel_index <= '0;
    end else if (cmd.accumulate) begin
      if (frame_end) begin
        frame_sum <= '0;
        channel_index <= '0;
      end else begin
        frame_sum <= frame_sum + samp;
        channel_index <= channel_index + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.div_start) begin
      cnt <= 6'(SumW);
      neg <= (frame_sum + samp) < 0;
      dividend <= ((frame_sum + samp) < 0) ? -(frame_sum + samp) : (frame_sum + samp);
      rem <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
      dividend <= dividend << 1;
      if (!trial[SumW]) begin
        rem <= trial[SumW-1:0];
        quot <= {quot[SumW-2:0], 1'b1};
      end else begin
        rem <= {rem[SumW-2:0], dividend[SumW-1]};
        quot <= {quot[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (fmt_eff)
        FmtInt24: level <= biased[23:16];
        FmtInt32: level <= biased[31:24];
        FmtFlt32, FmtFlt64: begin
          if (t < 0) level <= 8'd0;
          else if ((t >>> (FracBits + 1)) > 255) level <= 8'd255;
          else level <= t[FracBits+8:FracBits+1];
        end
        default:  level <= biased[15:8];
      endcase
    end
  end
endmodule

// ===== rtl/pcm_downmix_to_u8_mono_core.sv =====
// channel | dir | tdata fields (lsb up)  | tuser | tlast
// s_axis  | in  | sample_bits[63:0]      | -     | -
// m_axis  | out | mono_level[7:0]        | -     | -
// cfg     | in  | index 0 format, 1 channel count, data[3:0]
// one sample per cycle while ready; the frame's last sample starts the divider
// (36 restoring divider steps, a done check, then the level forms on output room)
// s_axis_tready drops while the divider runs or the level waits for output room
// rst is synchronous, clears sum, channel index, state, output valid
// a config write blocks s_axis_tready; while idle it also restarts the frame
module pcm_downmix_to_u8_mono_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,   // index 0 format, 1 channel count
  input  logic [3:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sample_bits[63:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // mono_level[7:0]
);
  import pdm_pkg::*;

  logic [2:0]       sample_format;
  logic [3:0]       channel_count;
  logic [ChanW-1:0] nch;
  pdm_cmd_t         cmd;
  pdm_sts_t         sts;
  logic             busy, frame_end, in_fire, out_free;

  // effective channel count, zero as one, clamp at max
  assign nch = (channel_count == '0) ? ChanW'(1) :
               (channel_count > 4'(MaxChannels)) ? ChanW'(MaxChannels) :
               ChanW'(channel_count);

  assign s_axis_tready = !busy && !cfg_we;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FmtInt16;
      channel_count <= 4'd2;
    end else if (cfg_we) begin
      if (cfg_index == RegFormat) sample_format <= cfg_data[2:0];
      else channel_count <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.finish) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  pdm_ctrl u_ctrl (
    .clk, .rst, .cfg_write(cfg_we), .in_fire, .frame_end, .out_free,
    .sts, .cmd, .busy
  );

  pdm_dp u_dp (
    .clk, .rst, .cmd, .fmt(sample_format), .nch, .sample_bits(s_axis_tdata),
    .frame_end, .sts, .level(m_axis_tdata)
  );

`include "pcm_downmix_to_u8_mono_core_assert.svh"

  `PDM_ASSERT_IMP(a_no_take_busy, busy, !in_fire, "input taken while dividing")
  `PDM_ASSERT_NEXT(a_fin_valid, cmd.finish, m_axis_tvalid, "finish without output")
  `PDM_ASSERT_IMP(a_fin_room, cmd.finish, out_free, "output overwritten")
endmodule
